// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/sha_pkg.sv =====
package sha_pkg;

    localparam int unsigned QDepth = 4;

    // Queue entry from the front part
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
    } t_item;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [5:0] PadLimit = 6'd56;
    localparam logic [7:0] PadByte  = 8'h80;

endpackage

// ===== src/sha_front.sv =====
// Input queue: takes items, saturates byte count, drops empty non-last words
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [31:0]    i_data_word,
    input  logic [2:0]     i_byte_count,
    input  logic           i_last,
    output logic           o_valid,
    output sha_pkg::t_item o_item,
    input  logic           i_take
);
    import sha_pkg::*;

    t_item       r_mem [QDepth];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        w_acc, w_keep;
    logic [2:0]  w_bc;

    assign o_full  = (r_cnt == 3'(QDepth));
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign w_acc   = i_push && !o_full;
    assign w_bc    = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign w_keep  = w_acc && (i_last || (w_bc != 3'd0));

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_mem[r_wp] <= '{data: i_data_word, cnt: w_bc, last: i_last};
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_keep) r_wp <= r_wp + 2'd1;
            if (i_take) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_keep} - {2'd0, i_take};
        end
    end
endmodule

// ===== src/sha_core.sv =====
// Back part: byte packing, padding, 64-round compression, digest output
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sha_pkg::t_item i_item,
    output logic           o_take,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_final_word
);
    import sha_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BYTE = 6'b000010,
        S_PAD  = 6'b000100,
        S_RND  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state      r_st, n_st;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [60:0] r_len;
    logic [6:0]  r_rnd;
    logic [31:0] r_data;
    logic [2:0]  r_left;
    logic [1:0]  r_bi;
    logic        r_last;
    logic        r_pad1;     // second pad block still to go
    logic        r_fin;      // current compression is the final one
    logic [2:0]  r_oi;

    logic [5:0]  w_pos;
    logic [7:0]  w_byte;
    logic [31:0] w_wt, w_s0, w_s1, w_wn, w_t1, w_t2, w_ch, w_mj, w_e, w_a;
    logic [63:0] w_bits;

    assign w_pos  = r_len[5:0];
    assign w_byte = r_data[31 - 8*r_bi -: 8];
    assign w_bits = {r_len, 3'b000};
    assign o_take = (r_st == S_IDLE) && i_valid;

    // Schedule word and round logic
    assign w_s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
    assign w_s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
                  ^ (r_w[14] >> 10);
    assign w_wn = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_wt = r_w[0];
    assign w_e  = r_v[4];
    assign w_a  = r_v[0];
    assign w_ch = (w_e & r_v[5]) ^ (~w_e & r_v[6]);
    assign w_mj = (w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1 = r_v[7] + ({w_e[5:0], w_e[31:6]} ^ {w_e[10:0], w_e[31:11]}
                  ^ {w_e[24:0], w_e[31:25]}) + w_ch + K_TAB[r_rnd[5:0]] + w_wt;
    assign w_t2 = ({w_a[1:0], w_a[31:2]} ^ {w_a[12:0], w_a[31:13]}
                  ^ {w_a[21:0], w_a[31:22]}) + w_mj;

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) n_st = S_BYTE;
            S_BYTE: begin
                if (r_left != 3'd0) begin
                    if (w_pos == 6'd63) n_st = S_RND;
                end else if (r_last) n_st = S_PAD;
                else n_st = S_IDLE;
            end
            S_PAD:  n_st = S_RND;
            S_RND:  if (r_rnd == 7'd63) n_st = S_ADD;
            S_ADD: begin
                if (r_fin) n_st = S_OUT;
                else if (r_pad1) n_st = S_PAD;
                else n_st = S_BYTE;
            end
            S_OUT:  if (i_pop && r_oi == 3'd7) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_len <= '0;
            r_rnd <= '0;
            r_oi  <= '0;
            r_fin <= 1'b0;
            r_pad1 <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: begin
                    r_fin  <= 1'b0;
                    r_pad1 <= 1'b0;
                end
                S_BYTE: if (r_left != 3'd0) r_len <= r_len + 61'd1;
                S_PAD: begin
                    if (!r_pad1) begin
                        if (w_pos + 6'd1 > PadLimit || w_pos == 6'd63) r_pad1 <= 1'b1;
                        else r_fin <= 1'b1;
                    end else begin
                        r_pad1 <= 1'b0;
                        r_fin  <= 1'b1;
                    end
                end
                S_RND: r_rnd <= (r_rnd == 7'd63) ? 7'd0 : r_rnd + 7'd1;
                S_ADD: for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                S_OUT: if (i_pop) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_len <= '0;
                        for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_valid) begin
                r_data <= i_item.data;
                r_left <= i_item.cnt;
                r_last <= i_item.last;
                r_bi   <= '0;
            end
            S_BYTE: if (r_left != 3'd0) begin
                r_w[w_pos[5:2]][31 - 8*w_pos[1:0] -: 8] <= w_byte;
                r_left <= r_left - 3'd1;
                r_bi   <= r_bi + 2'd1;
                if (w_pos == 6'd63) for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            S_PAD: begin
                for (int i = 0; i < 16; i++) begin
                    for (int b = 0; b < 4; b++) begin
                        if (!r_pad1) begin
                            if (6'(4*i + b) == w_pos)
                                r_w[i][31 - 8*b -: 8] <= PadByte;
                            else if (6'(4*i + b) > w_pos)
                                r_w[i][31 - 8*b -: 8] <= 8'h00;
                        end else begin
                            r_w[i][31 - 8*b -: 8] <= 8'h00;
                        end
                    end
                end
                if (r_pad1 || !(w_pos + 6'd1 > PadLimit || w_pos == 6'd63)) begin
                    r_w[14] <= w_bits[63:32];
                    r_w[15] <= w_bits[31:0];
                end
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            S_RND: begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_wn;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            default: ;
        endcase
    end

    assign o_empty       = (r_st != S_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_final_word  = (r_oi == 3'd7);
endmodule

// ===== src/sha256_hash_engine.sv =====
// SHA-256 engine.
// Input channel: push/full with data_word, byte_count (0..4, above 4 counts
// as 4) and last. Bytes are big-endian, first byte in bits 31:24.
// A four-item queue holds input items while the core works.
// The core takes one item from the queue while idle, packs one byte per
// cycle while no block is being compressed and then closes the item.
// A full 64-byte block then runs one round per cycle, 64 rounds, followed
// by a final add of the working values into the hash state; the engine
// rate is set by byte packing and the single round unit.
// On last the core pads (a pad step ahead of each block, one extra block when
// over 55 bytes remain), then shows the eight digest words H0..H7 on the
// empty/pop channel in order, one per cycle while popped; final_word marks H7.
// The core waits while the receiver stalls; new items still queue up until it is full.
// After the eighth word is popped the hash state reloads the standard
// initial values and the length count clears.
// Reset (synchronous, active low) empties the queue, loads the initial
// values and clears the length count; no clearing pass.
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);
    import sha_pkg::*;

    logic  w_valid, w_take;
    t_item w_item;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_data_word, .i_byte_count, .i_last,
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    sha_core u_core (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_item(w_item), .o_take(w_take),
        .o_empty(empty), .i_pop(pop),
        .o_digest_word, .o_word_index, .o_final_word
    );

`include "assert_macros.svh"

    `ASSERT_IMPL(a_take_valid, i_clk, i_rst_n, w_take, w_valid)
    `ASSERT_IMPL(a_final_idx, i_clk, i_rst_n, !empty && o_final_word, o_word_index == 3'd7)
    `ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, !empty && pop && !o_final_word,
                 !empty && o_word_index == $past(o_word_index) + 3'd1)
endmodule
